// ----- rtl/rv64dec_pkg.sv -----
package rv64dec_pkg;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned INSTR_W     = 32;
	localparam int unsigned PC_W        = 64;
	localparam int unsigned OP_ID_W     = 8;
	localparam int unsigned LEN_W       = 4;
	localparam int unsigned S_TDATA_W   = 96;
	localparam int unsigned M_TDATA_W   = 80;

	// Field positions in m_tdata
	localparam int unsigned M_OP_LSB    = 0;
	localparam int unsigned M_LEN_LSB   = 8;
	localparam int unsigned M_LEGAL_BIT = 12;
	localparam int unsigned M_PC_LSB    = 13;
	localparam int unsigned M_PAD_W     = M_TDATA_W - M_PC_LSB - PC_W;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_FLOAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_FLOAT = 2'd1;

	// Instruction lengths in bytes
	localparam logic [LEN_W-1:0] LEN_ILLEGAL = 4'd0;
	localparam logic [LEN_W-1:0] LEN_16      = 4'd2;
	localparam logic [LEN_W-1:0] LEN_32      = 4'd4;
	localparam logic [LEN_W-1:0] LEN_48      = 4'd6;
	localparam logic [LEN_W-1:0] LEN_64      = 4'd8;

	localparam logic [OP_ID_W-1:0] OP_NONE = 8'd0;
	localparam logic [OP_ID_W-1:0] OP_LAST = 8'd156;

	typedef struct packed {
		logic sp;
		logic dp;
	} fp_en_t;

	typedef struct packed {
		logic [LEN_W-1:0] length_bytes;
		logic             legal;
		logic [PC_W-1:0]  seq_next_pc;
	} len_res_t;

	typedef struct packed {
		logic [OP_ID_W-1:0] op_id;
		len_res_t           len;
	} dec_result_t;

endpackage

// ----- rtl/rv64dec_len.sv -----
module rv64dec_len (
	input  logic [6:0]                     instr_low,
	input  logic [rv64dec_pkg::PC_W-1:0]   fetch_pc,
	output rv64dec_pkg::len_res_t          res
);
	import rv64dec_pkg::*;

	logic [LEN_W-1:0] len;

	// Length from the run of trailing ones in the low opcode bits
	always_comb begin
		if (instr_low[1:0] != 2'b11) begin
			len = LEN_16;
		end else if (instr_low[4:2] != 3'b111) begin
			len = LEN_32;
		end else if (!instr_low[5]) begin
			len = LEN_48;
		end else if (!instr_low[6]) begin
			len = LEN_64;
		end else begin
			len = LEN_ILLEGAL;
		end
	end

	assign res.length_bytes = len;
	assign res.legal        = (instr_low != 7'h7f);
	assign res.seq_next_pc  = fetch_pc + PC_W'(len);

endmodule

// ----- rtl/rv64dec_op.sv -----
module rv64dec_op (
	input  logic [rv64dec_pkg::INSTR_W-1:0] instr_word,
	input  rv64dec_pkg::fp_en_t             fp_en,
	output logic [rv64dec_pkg::OP_ID_W-1:0] op_id
);
	import rv64dec_pkg::*;

	// Major opcodes, bits 6:2
	localparam logic [4:0] MAJ_LOAD      = 5'd0;
	localparam logic [4:0] MAJ_LOAD_FP   = 5'd1;
	localparam logic [4:0] MAJ_MISC_MEM  = 5'd3;
	localparam logic [4:0] MAJ_OP_IMM    = 5'd4;
	localparam logic [4:0] MAJ_AUIPC     = 5'd5;
	localparam logic [4:0] MAJ_OP_IMM_32 = 5'd6;
	localparam logic [4:0] MAJ_STORE     = 5'd8;
	localparam logic [4:0] MAJ_STORE_FP  = 5'd9;
	localparam logic [4:0] MAJ_AMO       = 5'd11;
	localparam logic [4:0] MAJ_OP        = 5'd12;
	localparam logic [4:0] MAJ_LUI       = 5'd13;
	localparam logic [4:0] MAJ_OP_32     = 5'd14;
	localparam logic [4:0] MAJ_MADD      = 5'd16;
	localparam logic [4:0] MAJ_MSUB      = 5'd17;
	localparam logic [4:0] MAJ_NMSUB     = 5'd18;
	localparam logic [4:0] MAJ_NMADD     = 5'd19;
	localparam logic [4:0] MAJ_OP_FP     = 5'd20;
	localparam logic [4:0] MAJ_BRANCH    = 5'd24;
	localparam logic [4:0] MAJ_JALR      = 5'd25;
	localparam logic [4:0] MAJ_JAL       = 5'd27;
	localparam logic [4:0] MAJ_SYSTEM    = 5'd28;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [5:0] F6_LOGIC  = 6'h00;
	localparam logic [5:0] F6_ARITH  = 6'h10;
	localparam logic [1:0] FMT_S     = 2'd0;
	localparam logic [1:0] FMT_D     = 2'd1;
	localparam logic [2:0] F3_W      = 3'd2;
	localparam logic [2:0] F3_D      = 3'd3;
	localparam logic [2:0] F3_SR     = 3'd5;
	localparam logic [11:0] IMM_ECALL  = 12'h000;
	localparam logic [11:0] IMM_EBREAK = 12'h001;

	// Operation numbers and group bases
	localparam logic [7:0] OP_LB        = 8'd1;
	localparam logic [7:0] OP_FLW       = 8'd8;
	localparam logic [7:0] OP_FLD       = 8'd9;
	localparam logic [7:0] OP_FENCE     = 8'd10;
	localparam logic [7:0] OP_ADDI      = 8'd12;
	localparam logic [7:0] OP_IMM_HI    = 8'd13;
	localparam logic [7:0] OP_SRLI      = 8'd17;
	localparam logic [7:0] OP_SRAI      = 8'd18;
	localparam logic [7:0] OP_AUIPC     = 8'd21;
	localparam logic [7:0] OP_ADDIW     = 8'd22;
	localparam logic [7:0] OP_SLLIW     = 8'd23;
	localparam logic [7:0] OP_SRLIW     = 8'd24;
	localparam logic [7:0] OP_SRAIW     = 8'd25;
	localparam logic [7:0] OP_SB        = 8'd26;
	localparam logic [7:0] OP_FSW       = 8'd30;
	localparam logic [7:0] OP_FSD       = 8'd31;
	localparam logic [7:0] OP_AMO_W     = 8'd31;
	localparam logic [7:0] OP_AMO_D     = 8'd42;
	localparam logic [7:0] OP_ADD       = 8'd54;
	localparam logic [7:0] OP_MUL       = 8'd62;
	localparam logic [7:0] OP_SUB       = 8'd70;
	localparam logic [7:0] OP_SRA       = 8'd71;
	localparam logic [7:0] OP_LUI       = 8'd72;
	localparam logic [7:0] OP_ADDW      = 8'd73;
	localparam logic [7:0] OP_SLLW      = 8'd74;
	localparam logic [7:0] OP_SRLW      = 8'd75;
	localparam logic [7:0] OP_MULW      = 8'd76;
	localparam logic [7:0] OP_DIVW_BASE = 8'd73;
	localparam logic [7:0] OP_SUBW      = 8'd81;
	localparam logic [7:0] OP_SRAW      = 8'd82;
	localparam logic [7:0] OP_FMADD_S   = 8'd83;
	localparam logic [7:0] OP_FMADD_D   = 8'd84;
	localparam logic [7:0] OP_FP_S      = 8'd91;
	localparam logic [7:0] OP_FP_D      = 8'd116;
	localparam logic [7:0] OP_BEQ       = 8'd141;
	localparam logic [7:0] OP_BLT_BASE  = 8'd139;
	localparam logic [7:0] OP_JALR      = 8'd147;
	localparam logic [7:0] OP_JAL       = 8'd148;
	localparam logic [7:0] OP_ECALL     = 8'd149;
	localparam logic [7:0] OP_EBREAK    = 8'd150;
	localparam logic [7:0] OP_CSR_BASE  = 8'd150;
	localparam logic [7:0] OP_CSRI_BASE = 8'd149;

	// OP-FP funct5 codes and slots within a precision block
	localparam logic [4:0] FP_ADD  = 5'h00;
	localparam logic [4:0] FP_SUB  = 5'h01;
	localparam logic [4:0] FP_MUL  = 5'h02;
	localparam logic [4:0] FP_DIV  = 5'h03;
	localparam logic [4:0] FP_SGNJ = 5'h04;
	localparam logic [4:0] FP_MNMX = 5'h05;
	localparam logic [4:0] FP_CVTF = 5'h08;
	localparam logic [4:0] FP_SQRT = 5'h0B;
	localparam logic [4:0] FP_CMP  = 5'h14;
	localparam logic [4:0] FP_CVTI = 5'h18;
	localparam logic [4:0] FP_CVTX = 5'h1A;
	localparam logic [4:0] FP_MVX  = 5'h1C;
	localparam logic [4:0] FP_MVF  = 5'h1E;
	localparam logic [4:0] SLOT_CVT_SD = 5'd9;
	localparam logic [4:0] SLOT_NONE   = 5'd25;

	// AMO funct5 codes
	localparam logic [4:0] AMO_ADD  = 5'h00;
	localparam logic [4:0] AMO_SWAP = 5'h01;
	localparam logic [4:0] AMO_LR   = 5'h02;
	localparam logic [4:0] AMO_SC   = 5'h03;
	localparam logic [4:0] AMO_XOR  = 5'h04;
	localparam logic [4:0] AMO_OR   = 5'h08;
	localparam logic [4:0] AMO_AND  = 5'h0C;
	localparam logic [4:0] AMO_MIN  = 5'h10;
	localparam logic [4:0] AMO_MAX  = 5'h14;
	localparam logic [4:0] AMO_MINU = 5'h18;
	localparam logic [4:0] AMO_MAXU = 5'h1C;

	function automatic logic [3:0] amo_slot(input logic [4:0] f5);
		logic [3:0] s;
		unique case (f5)
			AMO_ADD:  s = 4'd1;
			AMO_SWAP: s = 4'd2;
			AMO_LR:   s = 4'd3;
			AMO_SC:   s = 4'd4;
			AMO_XOR:  s = 4'd5;
			AMO_OR:   s = 4'd6;
			AMO_AND:  s = 4'd7;
			AMO_MIN:  s = 4'd8;
			AMO_MAX:  s = 4'd9;
			AMO_MINU: s = 4'd10;
			AMO_MAXU: s = 4'd11;
			default:  s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic logic [4:0] fp_slot(input logic [4:0] f5, input logic [2:0] f3,
			input logic [4:0] rs2);
		logic [4:0] s;
		unique case (f5)
			FP_ADD:  s = 5'd0;
			FP_SUB:  s = 5'd1;
			FP_MUL:  s = 5'd2;
			FP_DIV:  s = 5'd3;
			FP_SGNJ: s = (f3 <= 3'd2) ? 5'd4 + 5'(f3) : SLOT_NONE;
			FP_MNMX: s = (f3 <= 3'd1) ? 5'd7 + 5'(f3) : SLOT_NONE;
			FP_CVTF: s = SLOT_CVT_SD;
			FP_SQRT: s = 5'd10;
			FP_CMP:  s = (f3 <= 3'd2) ? 5'd11 + 5'(f3) : SLOT_NONE;
			FP_CVTI: s = (rs2 <= 5'd3) ? 5'd14 + rs2 : SLOT_NONE;
			FP_CVTX: s = (rs2 <= 5'd3) ? 5'd18 + rs2 : SLOT_NONE;
			FP_MVX:  s = (f3 <= 3'd1) ? 5'd22 + 5'(f3) : SLOT_NONE;
			FP_MVF:  s = (f3 == 3'd0) ? 5'd24 : SLOT_NONE;
			default: s = SLOT_NONE;
		endcase
		return s;
	endfunction

	logic [4:0]  major;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [5:0]  f6;
	logic [4:0]  f5;
	logic [1:0]  fmt;
	logic [4:0]  rs2;
	logic [11:0] imm;
	logic [3:0]  amo_s;
	logic [4:0]  fp_s;
	logic        is32;
	logic [7:0]  op_raw;

	assign major = instr_word[6:2];
	assign f3    = instr_word[14:12];
	assign f7    = instr_word[31:25];
	assign f6    = instr_word[31:26];
	assign f5    = instr_word[31:27];
	assign fmt   = instr_word[26:25];
	assign rs2   = instr_word[24:20];
	assign imm   = instr_word[31:20];
	assign amo_s = amo_slot(f5);
	assign fp_s  = fp_slot(f5, f3, rs2);
	assign is32  = (instr_word[1:0] == 2'b11) && (instr_word[4:2] != 3'b111);

	// Decode the 32-bit encoding space
	always_comb begin
		op_raw = OP_NONE;
		unique case (major)
			MAJ_LOAD: begin
				if (f3 != 3'd7) op_raw = OP_LB + 8'(f3);
			end
			MAJ_LOAD_FP: begin
				if (f3 == F3_W && fp_en.sp) op_raw = OP_FLW;
				else if (f3 == F3_D && fp_en.dp) op_raw = OP_FLD;
			end
			MAJ_MISC_MEM: begin
				if (f3 <= 3'd1) op_raw = OP_FENCE + 8'(f3);
			end
			MAJ_OP_IMM: begin
				if (f3 == F3_SR) begin
					if (f6 == F6_LOGIC) op_raw = OP_SRLI;
					else if (f6 == F6_ARITH) op_raw = OP_SRAI;
				end else if (f3 < F3_SR) begin
					op_raw = OP_ADDI + 8'(f3);
				end else begin
					op_raw = OP_IMM_HI + 8'(f3);
				end
			end
			MAJ_AUIPC: op_raw = OP_AUIPC;
			MAJ_OP_IMM_32: begin
				if (f3 == 3'd0) op_raw = OP_ADDIW;
				else if (f3 == 3'd1) op_raw = OP_SLLIW;
				else if (f3 == F3_SR && f7 == F7_BASE) op_raw = OP_SRLIW;
				else if (f3 == F3_SR && f7 == F7_ALT) op_raw = OP_SRAIW;
			end
			MAJ_STORE: begin
				if (f3 <= 3'd3) op_raw = OP_SB + 8'(f3);
			end
			MAJ_STORE_FP: begin
				if (f3 == F3_W && fp_en.sp) op_raw = OP_FSW;
				else if (f3 == F3_D && fp_en.dp) op_raw = OP_FSD;
			end
			MAJ_AMO: begin
				if (amo_s != 4'd0) begin
					if (f3 == F3_W) op_raw = OP_AMO_W + 8'(amo_s);
					else if (f3 == F3_D) op_raw = OP_AMO_D + 8'(amo_s);
				end
			end
			MAJ_OP: begin
				if (f7 == F7_BASE) op_raw = OP_ADD + 8'(f3);
				else if (f7 == F7_MULDIV) op_raw = OP_MUL + 8'(f3);
				else if (f7 == F7_ALT && f3 == 3'd0) op_raw = OP_SUB;
				else if (f7 == F7_ALT && f3 == F3_SR) op_raw = OP_SRA;
			end
			MAJ_LUI: op_raw = OP_LUI;
			MAJ_OP_32: begin
				if (f7 == F7_BASE) begin
					if (f3 == 3'd0) op_raw = OP_ADDW;
					else if (f3 == 3'd1) op_raw = OP_SLLW;
					else if (f3 == F3_SR) op_raw = OP_SRLW;
				end else if (f7 == F7_MULDIV) begin
					if (f3 == 3'd0) op_raw = OP_MULW;
					else if (f3 >= 3'd4) op_raw = OP_DIVW_BASE + 8'(f3);
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) op_raw = OP_SUBW;
					else if (f3 == F3_SR) op_raw = OP_SRAW;
				end
			end
			MAJ_MADD, MAJ_MSUB, MAJ_NMSUB, MAJ_NMADD: begin
				if (fmt == FMT_S && fp_en.sp) op_raw = OP_FMADD_S + 8'({major[1:0], 1'b0});
				else if (fmt == FMT_D && fp_en.dp) op_raw = OP_FMADD_D + 8'({major[1:0], 1'b0});
			end
			MAJ_OP_FP: begin
				if (fp_s != SLOT_NONE) begin
					if (fmt == FMT_S) begin
						if (fp_en.sp && (fp_s != SLOT_CVT_SD || fp_en.dp))
							op_raw = OP_FP_S + 8'(fp_s);
					end else if (fmt == FMT_D && fp_en.dp) begin
						op_raw = OP_FP_D + 8'(fp_s);
					end
				end
			end
			MAJ_BRANCH: begin
				if (f3 <= 3'd1) op_raw = OP_BEQ + 8'(f3);
				else if (f3 >= 3'd4) op_raw = OP_BLT_BASE + 8'(f3);
			end
			MAJ_JALR: begin
				if (f3 == 3'd0) op_raw = OP_JALR;
			end
			MAJ_JAL: op_raw = OP_JAL;
			MAJ_SYSTEM: begin
				if (f3 == 3'd0) begin
					if (imm == IMM_ECALL) op_raw = OP_ECALL;
					else if (imm == IMM_EBREAK) op_raw = OP_EBREAK;
				end else if (f3 <= 3'd3) begin
					op_raw = OP_CSR_BASE + 8'(f3);
				end else if (f3 >= 3'd5) begin
					op_raw = OP_CSRI_BASE + 8'(f3);
				end
			end
			default: op_raw = OP_NONE;
		endcase
	end

	// Only 4-byte words carry an operation
	assign op_id = is32 ? op_raw : OP_NONE;

endmodule

// ----- rtl/rv64_instruction_decoder.sv -----
// RV64IMAFD instruction decoder. Each request on the s_ side carries one
// instruction word and its pc; each result on the m_ side carries the
// operation number (0 for reserved or disabled encodings and non-32-bit words),
// the length in bytes, a legal flag and pc plus length. The block takes one
// request per clock unless m_ stalls, holds it in the input register and
// decodes it into the result register; backpressure on m_ holds the result
// register while an empty input register still fills. The user must write the
// cfg port float enables only while no request is in flight; not enforced.
module rv64_instruction_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rv64dec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                                 cfg_data,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rv64dec_pkg::S_TDATA_W-1:0]    s_tdata,  // instr_word[31:0], fetch_pc[95:32]
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rv64dec_pkg::M_TDATA_W-1:0]    m_tdata   // op_id[7:0], length_bytes[11:8],
	                                                       // legal[12], seq_next_pc[76:13]
);
	import rv64dec_pkg::*;

	fp_en_t              fp_en_q;
	logic                valid_s1;
	logic [INSTR_W-1:0]  instr_s1;
	logic [PC_W-1:0]     pc_s1;
	logic                valid_s2;
	dec_result_t         res_s2;
	logic                adv_s1;
	dec_result_t         res_d;

	// Float enables
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_en_q <= '{sp: 1'b1, dp: 1'b1};
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SINGLE_FLOAT) fp_en_q.sp <= cfg_data;
			else if (cfg_index == CFG_DOUBLE_FLOAT) fp_en_q.dp <= cfg_data;
		end
	end

	// Pipeline flow control
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s1) valid_s2 <= valid_s1;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			instr_s1 <= s_tdata[INSTR_W-1:0];
			pc_s1    <= s_tdata[INSTR_W +: PC_W];
		end
	end

	rv64dec_op u_op (
		.instr_word (instr_s1),
		.fp_en      (fp_en_q),
		.op_id      (res_d.op_id)
	);

	rv64dec_len u_len (
		.instr_low  (instr_s1[6:0]),
		.fetch_pc   (pc_s1),
		.res        (res_d.len)
	);

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) res_s2 <= res_d;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{M_PAD_W{1'b0}}, res_s2.len.seq_next_pc, res_s2.len.legal,
		res_s2.len.length_bytes, res_s2.op_id};

endmodule

// ----- rtl/rv64dec_chk.sv -----
module rv64dec_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [rv64dec_pkg::M_TDATA_W-1:0] m_tdata
);
	import rv64dec_pkg::*;

	logic [OP_ID_W-1:0] op;
	logic [LEN_W-1:0]   len;
	logic               legal;

	assign op    = m_tdata[M_OP_LSB +: OP_ID_W];
	assign len   = m_tdata[M_LEN_LSB +: LEN_W];
	assign legal = m_tdata[M_LEGAL_BIT];

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Illegal word has no length and no operation
	a_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !legal |-> len == LEN_ILLEGAL && op == OP_NONE)
		else $error("illegal word with length or operation");

	// Only 4-byte words decode to an operation
	a_op_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && op != OP_NONE |-> len == LEN_32 && legal && op <= OP_LAST)
		else $error("operation on non-32-bit word or out of range");

	// Legal words have a valid length
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && legal |-> len == LEN_16 || len == LEN_32 || len == LEN_48 || len == LEN_64)
		else $error("legal word with bad length");

	// Result stream empties once idle, unstalled cycles drain the input and result registers
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tvalid && m_tready ##1 !s_tvalid && m_tready |=> !m_tvalid)
		else $error("result appeared with no request");

endmodule

bind rv64_instruction_decoder rv64dec_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- test/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rv64dec_pkg::*;

	// Major opcodes (bits 6:2) that decode to something
	typedef enum logic [4:0] {
		MJ_LOAD      = 5'd0,
		MJ_LOAD_FP   = 5'd1,
		MJ_MISC_MEM  = 5'd3,
		MJ_OP_IMM    = 5'd4,
		MJ_AUIPC     = 5'd5,
		MJ_OP_IMM_32 = 5'd6,
		MJ_STORE     = 5'd8,
		MJ_STORE_FP  = 5'd9,
		MJ_AMO       = 5'd11,
		MJ_OP        = 5'd12,
		MJ_LUI       = 5'd13,
		MJ_OP_32     = 5'd14,
		MJ_MADD      = 5'd16,
		MJ_MSUB      = 5'd17,
		MJ_NMSUB     = 5'd18,
		MJ_NMADD     = 5'd19,
		MJ_OP_FP     = 5'd20,
		MJ_BRANCH    = 5'd24,
		MJ_JALR      = 5'd25,
		MJ_JAL       = 5'd27,
		MJ_SYSTEM    = 5'd28
	} major_t;

	// Operation numbers, or block bases that a field offset is added to
	localparam int OP_LB         = 1;
	localparam int OP_FLW        = 8;
	localparam int OP_FLD        = 9;
	localparam int OP_FENCE      = 10;
	localparam int OP_ADDI       = 12;
	localparam int OP_SRLI       = 17;
	localparam int OP_SRAI       = 18;
	localparam int OP_AUIPC      = 21;
	localparam int OP_ADDIW      = 22;
	localparam int OP_SLLIW      = 23;
	localparam int OP_SRLIW      = 24;
	localparam int OP_SRAIW      = 25;
	localparam int OP_SB         = 26;
	localparam int OP_FSW        = 30;
	localparam int OP_FSD        = 31;
	localparam int OP_AMO_W_BASE = 31;
	localparam int OP_AMO_D_BASE = 42;
	localparam int OP_ADD        = 54;
	localparam int OP_MUL        = 62;
	localparam int OP_SUB        = 70;
	localparam int OP_SRA        = 71;
	localparam int OP_LUI        = 72;
	localparam int OP_ADDW       = 73;
	localparam int OP_SLLW       = 74;
	localparam int OP_SRLW       = 75;
	localparam int OP_MULW       = 76;
	localparam int OP_SUBW       = 81;
	localparam int OP_SRAW       = 82;
	localparam int OP_FMADD_S    = 83;
	localparam int OP_FP_S       = 91;
	localparam int OP_FP_D       = 116;
	localparam int OP_BEQ        = 141;
	localparam int OP_JALR       = 147;
	localparam int OP_JAL        = 148;
	localparam int OP_ECALL      = 149;
	localparam int OP_EBREAK     = 150;
	localparam int OP_CSRRW      = 151;
	localparam int OP_CSRRWI     = 154;

	// funct3 values with a meaning of their own
	localparam logic [2:0] F3_BASE  = 3'd0;
	localparam logic [2:0] F3_SLL   = 3'd1;
	localparam logic [2:0] F3_W     = 3'd2;
	localparam logic [2:0] F3_D     = 3'd3;
	localparam logic [2:0] F3_SR    = 3'd5;
	localparam logic [2:0] F3_LWU   = 3'd6;

	// funct7 / funct6 selectors
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [5:0] F6_SRL    = 6'h00;
	localparam logic [5:0] F6_SRA    = 6'h10;

	// Float format field
	localparam logic [1:0] FMT_S = 2'd0;
	localparam logic [1:0] FMT_D = 2'd1;

	// SYSTEM immediates with funct3 zero
	localparam logic [11:0] IMM_ECALL  = 12'd0;
	localparam logic [11:0] IMM_EBREAK = 12'd1;

	// AMO funct5
	localparam logic [4:0] AMO_ADD  = 5'h00;
	localparam logic [4:0] AMO_SWAP = 5'h01;
	localparam logic [4:0] AMO_LR   = 5'h02;
	localparam logic [4:0] AMO_SC   = 5'h03;
	localparam logic [4:0] AMO_XOR  = 5'h04;
	localparam logic [4:0] AMO_OR   = 5'h08;
	localparam logic [4:0] AMO_AND  = 5'h0C;
	localparam logic [4:0] AMO_MIN  = 5'h10;
	localparam logic [4:0] AMO_MAX  = 5'h14;
	localparam logic [4:0] AMO_MINU = 5'h18;
	localparam logic [4:0] AMO_MAXU = 5'h1C;

	// OP-FP funct5
	localparam logic [4:0] FP_ADD    = 5'h00;
	localparam logic [4:0] FP_SUB    = 5'h01;
	localparam logic [4:0] FP_MUL    = 5'h02;
	localparam logic [4:0] FP_DIV    = 5'h03;
	localparam logic [4:0] FP_SGNJ   = 5'h04;
	localparam logic [4:0] FP_MINMAX = 5'h05;
	localparam logic [4:0] FP_CVT_FF = 5'h08;
	localparam logic [4:0] FP_SQRT   = 5'h0B;
	localparam logic [4:0] FP_CMP    = 5'h14;
	localparam logic [4:0] FP_CVT_I  = 5'h18;
	localparam logic [4:0] FP_CVT_F  = 5'h1A;
	localparam logic [4:0] FP_MV_X   = 5'h1C;
	localparam logic [4:0] FP_MV_F   = 5'h1E;

	localparam int FP_SLOT_CVT_FF   = 9;
	localparam int FP_SLOT_RESERVED = 25;

	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 100;
	localparam int NUM_PHASES  = 7;

	class dec_scoreboard;
		fp_en_t      en;
		dec_result_t due[$];
		int          errors;

		function new();
			en.sp = 1'b1;
			en.dp = 1'b1;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic d);
			if (idx == CFG_SINGLE_FLOAT) begin
				en.sp = d;
			end else if (idx == CFG_DOUBLE_FLOAT) begin
				en.dp = d;
			end
		endfunction

		function int amo_offset(logic [4:0] f5);
			case (f5)
				AMO_ADD:  return 1;
				AMO_SWAP: return 2;
				AMO_LR:   return 3;
				AMO_SC:   return 4;
				AMO_XOR:  return 5;
				AMO_OR:   return 6;
				AMO_AND:  return 7;
				AMO_MIN:  return 8;
				AMO_MAX:  return 9;
				AMO_MINU: return 10;
				AMO_MAXU: return 11;
				default:  return 0;
			endcase
		endfunction

		// Offset within one precision block of OP-FP
		function int fp_offset(logic [4:0] f5, logic [2:0] f3, logic [4:0] rs2);
			case (f5)
				FP_ADD:    return 0;
				FP_SUB:    return 1;
				FP_MUL:    return 2;
				FP_DIV:    return 3;
				FP_SGNJ:   return f3 <= 3'd2 ? 4 + f3 : FP_SLOT_RESERVED;
				FP_MINMAX: return f3 <= 3'd1 ? 7 + f3 : FP_SLOT_RESERVED;
				FP_CVT_FF: return FP_SLOT_CVT_FF;
				FP_SQRT:   return 10;
				FP_CMP:    return f3 <= 3'd2 ? 11 + f3 : FP_SLOT_RESERVED;
				FP_CVT_I:  return rs2 <= 5'd3 ? 14 + rs2 : FP_SLOT_RESERVED;
				FP_CVT_F:  return rs2 <= 5'd3 ? 18 + rs2 : FP_SLOT_RESERVED;
				FP_MV_X:   return f3 <= 3'd1 ? 22 + f3 : FP_SLOT_RESERVED;
				FP_MV_F:   return f3 == F3_BASE ? 24 : FP_SLOT_RESERVED;
				default:   return FP_SLOT_RESERVED;
			endcase
		endfunction

		// Operation number of a 32-bit word under the current float enables
		function int decode_op(logic [31:0] w);
			logic [4:0]  major;
			logic [2:0]  f3;
			logic [6:0]  f7;
			logic [5:0]  f6;
			logic [1:0]  fmt;
			logic [11:0] imm;
			int          s;
			major = w[6:2];
			f3    = w[14:12];
			f7    = w[31:25];
			f6    = w[31:26];
			fmt   = w[26:25];
			imm   = w[31:20];
			case (major)
				MJ_LOAD:      return f3 <= F3_LWU ? OP_LB + f3 : 0;
				MJ_LOAD_FP: begin
					if (f3 == F3_W && en.sp) return OP_FLW;
					if (f3 == F3_D && en.dp) return OP_FLD;
					return 0;
				end
				MJ_MISC_MEM:  return f3 <= 3'd1 ? OP_FENCE + f3 : 0;
				MJ_OP_IMM: begin
					if (f3 == F3_SR) begin
						if (f6 == F6_SRL) return OP_SRLI;
						if (f6 == F6_SRA) return OP_SRAI;
						return 0;
					end
					return f3 < F3_SR ? OP_ADDI + f3 : OP_ADDI + 1 + f3;
				end
				MJ_AUIPC:     return OP_AUIPC;
				MJ_OP_IMM_32: begin
					if (f3 == F3_BASE) return OP_ADDIW;
					if (f3 == F3_SLL) return OP_SLLIW;
					if (f3 == F3_SR && f7 == F7_BASE) return OP_SRLIW;
					if (f3 == F3_SR && f7 == F7_ALT) return OP_SRAIW;
					return 0;
				end
				MJ_STORE:     return f3 <= F3_D ? OP_SB + f3 : 0;
				MJ_STORE_FP: begin
					if (f3 == F3_W && en.sp) return OP_FSW;
					if (f3 == F3_D && en.dp) return OP_FSD;
					return 0;
				end
				MJ_AMO: begin
					s = amo_offset(w[31:27]);
					if (s == 0) return 0;
					if (f3 == F3_W) return OP_AMO_W_BASE + s;
					if (f3 == F3_D) return OP_AMO_D_BASE + s;
					return 0;
				end
				MJ_OP: begin
					if (f7 == F7_BASE) return OP_ADD + f3;
					if (f7 == F7_MULDIV) return OP_MUL + f3;
					if (f7 == F7_ALT && f3 == F3_BASE) return OP_SUB;
					if (f7 == F7_ALT && f3 == F3_SR) return OP_SRA;
					return 0;
				end
				MJ_LUI:       return OP_LUI;
				MJ_OP_32: begin
					if (f7 == F7_BASE) begin
						if (f3 == F3_BASE) return OP_ADDW;
						if (f3 == F3_SLL) return OP_SLLW;
						if (f3 == F3_SR) return OP_SRLW;
					end else if (f7 == F7_MULDIV) begin
						if (f3 == F3_BASE) return OP_MULW;
						if (f3 >= 3'd4) return OP_ADDW + f3;
					end else if (f7 == F7_ALT) begin
						if (f3 == F3_BASE) return OP_SUBW;
						if (f3 == F3_SR) return OP_SRAW;
					end
					return 0;
				end
				MJ_MADD, MJ_MSUB, MJ_NMSUB, MJ_NMADD: begin
					if (fmt == FMT_S && en.sp) return OP_FMADD_S + 2 * (major - MJ_MADD);
					if (fmt == FMT_D && en.dp) return OP_FMADD_S + 1 + 2 * (major - MJ_MADD);
					return 0;
				end
				MJ_OP_FP: begin
					s = fp_offset(w[31:27], f3, w[24:20]);
					if (s >= FP_SLOT_RESERVED) return 0;
					if (fmt == FMT_S) begin
						if (!en.sp) return 0;
						// S-from-D conversion also needs double enabled
						if (s == FP_SLOT_CVT_FF && !en.dp) return 0;
						return OP_FP_S + s;
					end
					if (fmt == FMT_D && en.dp) return OP_FP_D + s;
					return 0;
				end
				MJ_BRANCH: begin
					if (f3 <= 3'd1) return OP_BEQ + f3;
					if (f3 >= 3'd4) return OP_BEQ - 2 + f3;
					return 0;
				end
				MJ_JALR:      return f3 == F3_BASE ? OP_JALR : 0;
				MJ_JAL:       return OP_JAL;
				MJ_SYSTEM: begin
					if (f3 == F3_BASE) begin
						if (imm == IMM_ECALL) return OP_ECALL;
						if (imm == IMM_EBREAK) return OP_EBREAK;
						return 0;
					end
					if (f3 <= 3'd3) return OP_CSRRW - 1 + f3;
					if (f3 >= F3_SR) return OP_CSRRWI - F3_SR + f3;
					return 0;
				end
				default:      return 0;
			endcase
		endfunction

		// Work out the result of an accepted request and queue it
		function void note_request(logic [31:0] word, logic [63:0] pc);
			dec_result_t e;
			int          ones;
			ones = 0;
			while (ones < 7 && word[ones]) ones++;
			e.op_id = OP_NONE;
			e.len.legal = 1'b1;
			if (ones <= 1) begin
				e.len.length_bytes = LEN_16;
			end else if (ones <= 4) begin
				e.len.length_bytes = LEN_32;
				e.op_id = OP_ID_W'(decode_op(word));
			end else if (ones == 5) begin
				e.len.length_bytes = LEN_48;
			end else if (ones == 6) begin
				e.len.length_bytes = LEN_64;
			end else begin
				e.len.length_bytes = LEN_ILLEGAL;
				e.len.legal = 1'b0;
			end
			e.len.seq_next_pc = pc + 64'(e.len.length_bytes);
			due.push_back(e);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("tb: %s mismatch: got %0h, want %0h", what, got, want);
		endtask

		// Compare one result with the oldest expectation
		task check_result(logic [M_TDATA_W-1:0] d);
			dec_result_t e;
			if (due.size() == 0) begin
				report_mismatch("unexpected result", d[M_OP_LSB +: OP_ID_W], 0);
				return;
			end
			e = due.pop_front();
			if (d[M_OP_LSB +: OP_ID_W] !== e.op_id)
				report_mismatch("op_id", d[M_OP_LSB +: OP_ID_W], e.op_id);
			if (d[M_LEN_LSB +: LEN_W] !== e.len.length_bytes)
				report_mismatch("length_bytes", d[M_LEN_LSB +: LEN_W], e.len.length_bytes);
			if (d[M_LEGAL_BIT] !== e.len.legal)
				report_mismatch("legal", d[M_LEGAL_BIT], e.len.legal);
			if (d[M_PC_LSB +: PC_W] !== e.len.seq_next_pc)
				report_mismatch("seq_next_pc", d[M_PC_LSB +: PC_W], e.len.seq_next_pc);
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data  = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	dec_scoreboard sb = new();

	int s_idle_pct  = 0;
	int r_stall_pct = 0;
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_cnt    = 0;

	major_t     maj_list[21] = '{MJ_LOAD, MJ_LOAD_FP, MJ_MISC_MEM, MJ_OP_IMM, MJ_AUIPC,
		MJ_OP_IMM_32, MJ_STORE, MJ_STORE_FP, MJ_AMO, MJ_OP, MJ_LUI, MJ_OP_32, MJ_MADD,
		MJ_MSUB, MJ_NMSUB, MJ_NMADD, MJ_OP_FP, MJ_BRANCH, MJ_JALR, MJ_JAL, MJ_SYSTEM};
	logic [4:0] amo_list[11] = '{AMO_ADD, AMO_SWAP, AMO_LR, AMO_SC, AMO_XOR, AMO_OR,
		AMO_AND, AMO_MIN, AMO_MAX, AMO_MINU, AMO_MAXU};
	logic [4:0] fp_list[13] = '{FP_ADD, FP_SUB, FP_MUL, FP_DIV, FP_SGNJ, FP_MINMAX,
		FP_CVT_FF, FP_SQRT, FP_CMP, FP_CVT_I, FP_CVT_F, FP_MV_X, FP_MV_F};

	// Directed words with their pcs
	logic [31:0] dir_word[15] = '{32'hFC001013, 32'h03F05013, 32'h43F05013, 32'h04005013,
		32'h00001067, 32'h000F8F73, 32'h00100073, 32'h1650302F, 32'hFFFFF073,
		32'h0000007F, 32'hFFFFFFFF, 32'hFFFFFFFD, 32'h0000001F, 32'h0000003F,
		32'h00000000};
	logic [63:0] dir_pc[15] = '{64'h0000_0000_8000_0000, 64'h0000_0000_8000_0004,
		64'h7FFF_FFFF_FFFF_FFFC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_1000,
		64'hA5A5_5A5A_A5A5_5A5A, 64'h5A5A_A5A5_5A5A_A5A5, 64'h0000_0000_0001_0000,
		64'hFFFF_FFFF_FFFF_FFFB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC, 64'hFFFF_FFFF_FFFF_FFFD,
		64'h0000_0000_0000_0000};
	// Float loads and the S-from-D conversion, replayed under each enable setting
	logic [31:0] fp_word[3] = '{32'h00002007, 32'h00003007, 32'h40100053};

	// Per-phase enable settings
	logic sp_set[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
	logic dp_set[NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

	rv64_instruction_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drive the result side: long hold when asked, else random stalls
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			m_tready = 1'b0;
			hold_cnt--;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_cnt = HOLD_CYCLES;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= r_stall_pct);
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		int          r;
		int          k;
		w = $urandom;
		r = $urandom_range(99);
		if (r < 8) begin
			// non-32-bit lengths and the illegal pattern
			k = $urandom_range(3);
			case (k)
				0: w[1:0] = 2'($urandom_range(2));
				1: begin w[4:0] = 5'h1F; w[5] = 1'b0; end
				2: begin w[5:0] = 6'h3F; w[6] = 1'b0; end
				default: w[6:0] = 7'h7F;
			endcase
		end else if (r >= 20) begin
			// well-formed 32-bit word with random operands
			w[6:2] = maj_list[$urandom_range(20)];
			w[1:0] = 2'b11;
			case (w[6:2])
				MJ_OP, MJ_OP_32, MJ_OP_IMM_32: begin
					k = $urandom_range(3);
					if (k == 0) w[31:25] = F7_BASE;
					else if (k == 1) w[31:25] = F7_MULDIV;
					else if (k == 2) w[31:25] = F7_ALT;
				end
				MJ_OP_IMM: begin
					k = $urandom_range(2);
					if (k == 0) w[31:26] = F6_SRL;
					else if (k == 1) w[31:26] = F6_SRA;
				end
				MJ_AMO: begin
					k = $urandom_range(11);
					if (k < 11) w[31:27] = amo_list[k];
					if ($urandom_range(3) != 0) w[14:12] = F3_W + 3'($urandom_range(1));
				end
				MJ_OP_FP: begin
					k = $urandom_range(13);
					if (k < 13) w[31:27] = fp_list[k];
					if ($urandom_range(3) != 0) w[26:25] = 2'($urandom_range(1));
					if ($urandom_range(1) != 0) w[24:20] = 5'($urandom_range(3));
					if ($urandom_range(1) != 0) w[14:12] = 3'($urandom_range(2));
				end
				MJ_MADD, MJ_MSUB, MJ_NMSUB, MJ_NMADD: begin
					if ($urandom_range(3) != 0) w[26:25] = 2'($urandom_range(1));
				end
				MJ_LOAD_FP, MJ_STORE_FP: begin
					if ($urandom_range(3) != 0) w[14:12] = F3_W + 3'($urandom_range(1));
				end
				MJ_SYSTEM: begin
					if ($urandom_range(1) != 0) begin
						w[31:20] = 12'($urandom_range(1));
						w[14:12] = F3_BASE;
					end
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	function automatic logic [63:0] rand_pc();
		case ($urandom_range(9))
			0:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(7));
			1:       return 64'($urandom_range(15));
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Offer one request, with random idle cycles before it; returns at a falling edge
	task automatic push_req(input logic [31:0] word, input logic [63:0] pc);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {pc, word};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(word, pc);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stop offering and let every outstanding result drain
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed part, both enables on, no idling
		write_reg(CFG_SINGLE_FLOAT, 1'b1);
		write_reg(CFG_DOUBLE_FLOAT, 1'b1);
		for (int i = 0; i < 15; i++) push_req(dir_word[i], dir_pc[i]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_reg(CFG_SINGLE_FLOAT, sp_set[p]);
			write_reg(CFG_DOUBLE_FLOAT, dp_set[p]);
			if (p == 3) begin
				write_reg(CFG_SPARE_2, 1'b0);
				write_reg(CFG_SPARE_3, 1'b0);
			end
			case (p % 4)
				0: begin s_idle_pct = 0;  r_stall_pct = 0;  end
				1: begin s_idle_pct = 82; r_stall_pct = 0;  end
				2: begin s_idle_pct = 0;  r_stall_pct = 82; end
				default: begin s_idle_pct = 17; r_stall_pct = 17; end
			endcase
			if (p < 4) begin
				for (int i = 0; i < 3; i++) push_req(fp_word[i], rand_pc());
			end
			// hold the result side off while requests keep coming
			if (p == 4) holds_asked++;
			repeat (PHASE_ITEMS) push_req(rand_word(), rand_pc());
		end

		s_tvalid = 1'b0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
